@@ hdl/ofs_pkg.sv @@
// Shared types, codes and arithmetic helpers for the offboard flight sequencer.
// No dependencies; used by ofs_front, ofs_back and the core.
`default_nettype none
package ofs_pkg;

	typedef enum logic [2:0] {
		OP_STATUS   = 3'd0,
		OP_POSITION = 3'd1,
		OP_COMMAND  = 3'd2,
		OP_SEQ_TICK = 3'd3,
		OP_SP_TICK  = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_ARM      = 3'd0,
		KIND_OFFBOARD = 3'd1,
		KIND_TAKEOFF  = 3'd2,
		KIND_HOLD     = 3'd3,
		KIND_VELOCITY = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ARMING   = 3'd1,
		PH_PREP     = 3'd2,
		PH_TAKEOFF  = 3'd3,
		PH_OFFBOARD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_EMIT2 = 2'd1,
		BK_ROT   = 2'd2
	} back_state_t;

	typedef enum logic [1:0] {
		REG_TAKEOFF_ALT = 2'd0,
		REG_CMD_TIMEOUT = 2'd1,
		REG_ARM_SETTLE  = 2'd2,
		REG_PREP_TICKS  = 2'd3
	} reg_index_t;

	localparam logic [7:0]  ARMED_CODE   = 8'd2;
	localparam logic [16:0] SIN_A        = 17'd51472;
	localparam logic [15:0] SIN_B        = 16'd21024;
	localparam logic [11:0] SIN_C        = 12'd2320;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	typedef struct packed {
		logic [2:0]         kind;
		logic               two;
		logic               vel;
		logic signed [23:0] n;
		logic signed [23:0] e;
		logic signed [23:0] d;
		logic signed [15:0] r;
		logic [15:0]        hdg;
	} job_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [23:0] n;
		logic signed [23:0] e;
		logic signed [23:0] d;
		logic signed [15:0] r;
		logic               last;
	} res_t;

	// Q15 to integer, ties away from zero.
	function automatic logic signed [23:0] round_q15(input logic signed [35:0] v);
		logic signed [35:0] a;
		logic signed [35:0] m;
		begin
			if (v >= 0) begin
				a = (v + 36'sd16384) >>> 15;
			end else begin
				m = -v;
				a = -((m + 36'sd16384) >>> 15);
			end
			round_q15 = a[23:0];
		end
	endfunction

endpackage
`default_nettype wire

@@ hdl/ofs_fifo.sv @@
// Small synchronous queue with register storage.
// No dependencies; used for the job queue and the result queue.
`default_nettype none
module ofs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH_LOG2 = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int DEPTH = 2 ** DEPTH_LOG2;

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [DEPTH_LOG2:0] wr_q;
	logic [DEPTH_LOG2:0] rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[DEPTH_LOG2-1:0] == rd_q[DEPTH_LOG2-1:0]) &&
	               (wr_q[DEPTH_LOG2] != rd_q[DEPTH_LOG2]);
	assign rdata = mem_q[rd_q[DEPTH_LOG2-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q[DEPTH_LOG2-1:0]] <= wdata;
		end
	end
endmodule
`default_nettype wire

@@ hdl/ofs_front.sv @@
// Front end: configuration registers, event decode, flight sequence state.
// Depends on ofs_pkg; emits jobs for ofs_back through the job queue.
`default_nettype none
module ofs_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [2:0]         opcode,
	input  wire logic               checks_pass,
	input  wire logic [7:0]         arming_code,
	input  wire logic signed [23:0] north_mm,
	input  wire logic signed [23:0] east_mm,
	input  wire logic signed [23:0] down_mm,
	input  wire logic signed [15:0] heading,
	input  wire logic signed [15:0] fwd_speed,
	input  wire logic signed [15:0] left_speed,
	input  wire logic signed [15:0] up_speed,
	input  wire logic signed [15:0] ccw_rate,
	input  wire logic               cfg_we,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [16:0]        cfg_data,
	output logic                    job_push,
	output ofs_pkg::job_t           job
);
	logic [16:0] alt_q;
	logic [7:0]  timeout_q, settle_q, prep_q;

	ofs_pkg::phase_t    phase_q;
	logic [7:0]         cnt_q;
	logic               checks_q;
	logic [7:0]         armed_q;
	logic signed [23:0] pos_q [3];
	logic [15:0]        hdg_q;
	logic               known_q;
	logic signed [15:0] cmd_q [4];
	logic               seen_q;
	logic [7:0]         tsc_q;
	logic               active_q;
	logic               hcap_q;
	logic signed [23:0] hover_q [3];

	logic [7:0]         cnt_inc;
	logic [7:0]         tsc_inc;
	logic               fresh;
	logic               reached;
	logic signed [29:0] lhs, rhs;
	logic signed [24:0] neg_down;
	logic signed [23:0] tz;
	logic signed [16:0] neg_ccw;

	assign cnt_inc  = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
	assign tsc_inc  = (tsc_q == 8'hFF) ? tsc_q : tsc_q + 8'd1;
	assign fresh    = seen_q && (tsc_q < timeout_q);
	assign neg_down = -{pos_q[2][23], pos_q[2]};
	assign lhs      = ({{5{neg_down[24]}}, neg_down} <<< 3) +
	                  ({{5{neg_down[24]}}, neg_down} <<< 1);
	assign rhs      = $signed({13'd0, alt_q}) * 30'sd9;
	assign reached  = (lhs >= rhs);
	assign tz       = -$signed({7'd0, alt_q});
	assign neg_ccw  = -{cmd_q[3][15], cmd_q[3]};

	always_comb begin
		job_push = 1'b0;
		job      = '0;
		if (accept) begin
			unique case (opcode)
				ofs_pkg::OP_SEQ_TICK: begin
					unique case (phase_q)
						ofs_pkg::PH_ARMING: begin
							job_push = 1'b1;
							job.kind = ofs_pkg::KIND_ARM;
						end
						ofs_pkg::PH_PREP: begin
							job_push = 1'b1;
							job.kind = ofs_pkg::KIND_TAKEOFF;
							job.d    = tz;
							job.two  = (cnt_inc >= prep_q);
						end
						ofs_pkg::PH_TAKEOFF: begin
							job_push = 1'b1;
							job.kind = ofs_pkg::KIND_TAKEOFF;
							job.d    = tz;
						end
						default: ;
					endcase
				end
				ofs_pkg::OP_SP_TICK: begin
					if (active_q && known_q) begin
						job_push = 1'b1;
						if (fresh) begin
							job.kind = ofs_pkg::KIND_VELOCITY;
							job.vel  = 1'b1;
							job.n    = {{8{cmd_q[0][15]}}, cmd_q[0]};
							job.e    = {{8{cmd_q[1][15]}}, cmd_q[1]};
							job.d    = -{{8{cmd_q[2][15]}}, cmd_q[2]};
							job.r    = (neg_ccw > 17'sd32767) ? 16'sd32767 : neg_ccw[15:0];
							job.hdg  = hdg_q;
						end else begin
							job.kind = ofs_pkg::KIND_HOLD;
							job.n    = hcap_q ? hover_q[0] : pos_q[0];
							job.e    = hcap_q ? hover_q[1] : pos_q[1];
							job.d    = hcap_q ? hover_q[2] : pos_q[2];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q     <= 17'd1500;
			timeout_q <= 8'd25;
			settle_q  <= 8'd10;
			prep_q    <= 8'd20;
			phase_q   <= ofs_pkg::PH_IDLE;
			cnt_q     <= '0;
			checks_q  <= 1'b0;
			armed_q   <= '0;
			pos_q     <= '{default: '0};
			hdg_q     <= '0;
			known_q   <= 1'b0;
			cmd_q     <= '{default: '0};
			seen_q    <= 1'b0;
			tsc_q     <= '0;
			active_q  <= 1'b0;
			hcap_q    <= 1'b0;
			hover_q   <= '{default: '0};
		end else begin
			if (cfg_we && cfg_index[3:2] == 2'd0) begin
				unique case (ofs_pkg::reg_index_t'(cfg_index[1:0]))
					ofs_pkg::REG_TAKEOFF_ALT: alt_q     <= cfg_data;
					ofs_pkg::REG_CMD_TIMEOUT: timeout_q <= cfg_data[7:0];
					ofs_pkg::REG_ARM_SETTLE:  settle_q  <= cfg_data[7:0];
					ofs_pkg::REG_PREP_TICKS:  prep_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (accept) begin
				unique case (opcode)
					ofs_pkg::OP_STATUS: begin
						checks_q <= checks_pass;
						armed_q  <= arming_code;
					end
					ofs_pkg::OP_POSITION: begin
						pos_q[0] <= north_mm;
						pos_q[1] <= east_mm;
						pos_q[2] <= down_mm;
						hdg_q    <= heading;
						known_q  <= 1'b1;
					end
					ofs_pkg::OP_COMMAND: begin
						cmd_q[0] <= fwd_speed;
						cmd_q[1] <= left_speed;
						cmd_q[2] <= up_speed;
						cmd_q[3] <= ccw_rate;
						seen_q   <= 1'b1;
						tsc_q    <= '0;
						hcap_q   <= 1'b0;
					end
					ofs_pkg::OP_SEQ_TICK: begin
						unique case (phase_q)
							ofs_pkg::PH_IDLE: begin
								if (checks_q) begin
									phase_q <= ofs_pkg::PH_ARMING;
									cnt_q   <= '0;
								end
							end
							ofs_pkg::PH_ARMING: begin
								if (!checks_q) begin
									phase_q <= ofs_pkg::PH_IDLE;
									cnt_q   <= cnt_inc;
								end else if (armed_q == ofs_pkg::ARMED_CODE &&
								             cnt_q > settle_q) begin
									phase_q <= ofs_pkg::PH_PREP;
									cnt_q   <= 8'd1;
								end else begin
									cnt_q <= cnt_inc;
								end
							end
							ofs_pkg::PH_PREP: begin
								if (cnt_inc >= prep_q) begin
									phase_q <= ofs_pkg::PH_TAKEOFF;
									cnt_q   <= '0;
								end else begin
									cnt_q <= cnt_inc;
								end
							end
							ofs_pkg::PH_TAKEOFF: begin
								if (reached) begin
									phase_q  <= ofs_pkg::PH_OFFBOARD;
									active_q <= 1'b1;
									hover_q  <= pos_q;
								end
							end
							ofs_pkg::PH_OFFBOARD: begin
								if (!checks_q || armed_q != ofs_pkg::ARMED_CODE) begin
									phase_q  <= ofs_pkg::PH_IDLE;
									active_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
					ofs_pkg::OP_SP_TICK: begin
						tsc_q <= tsc_inc;
						if (active_q && known_q && !fresh && !hcap_q) begin
							hcap_q  <= 1'b1;
							hover_q <= pos_q;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/ofs_back.sv @@
// Back end: turns queued jobs into results; velocity jobs run the sine
// polynomial and the body-to-NED rotation in sequence. Depends on ofs_pkg.
`default_nettype none
module ofs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_empty,
	input  wire ofs_pkg::job_t job,
	output logic               job_pop,
	input  wire logic          res_full,
	output logic               res_push,
	output ofs_pkg::res_t      res
);
	ofs_pkg::back_state_t state_q, state_d;
	logic [2:0]           step_q;

	logic [14:0]        xs_q, xc_q, x2s_q, x2c_q;
	logic [15:0]        ts_q, tc_q;
	logic               negs_q, negc_q;
	logic signed [17:0] sin_q, cos_q;
	logic signed [33:0] p_q [4];

	logic [15:0]        hc;
	logic [14:0]        xs0, xc0;
	logic [29:0]        sq_s, sq_c;
	logic [26:0]        mc_s, mc_c;
	logic [30:0]        mt_s, mt_c;
	logic [30:0]        ms_s, ms_c;
	logic [16:0]        mag_s, mag_c;
	logic signed [35:0] sum_n, sum_e;

	assign hc  = job.hdg + ofs_pkg::QUARTER_TURN;
	assign xs0 = job.hdg[14] ? 15'd16384 - {1'b0, job.hdg[13:0]} : {1'b0, job.hdg[13:0]};
	assign xc0 = hc[14] ? 15'd16384 - {1'b0, hc[13:0]} : {1'b0, hc[13:0]};

	assign sq_s  = xs_q * xs_q;
	assign sq_c  = xc_q * xc_q;
	assign mc_s  = ofs_pkg::SIN_C * x2s_q;
	assign mc_c  = ofs_pkg::SIN_C * x2c_q;
	assign mt_s  = ts_q * x2s_q;
	assign mt_c  = tc_q * x2c_q;
	assign ms_s  = ts_q * xs_q;
	assign ms_c  = tc_q * xc_q;
	assign mag_s = ms_s[30:14];
	assign mag_c = ms_c[30:14];
	assign sum_n = 36'(p_q[0]) + 36'(p_q[1]);
	assign sum_e = 36'(p_q[2]) - 36'(p_q[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ofs_pkg::BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ofs_pkg::BK_ROT) begin
				if (step_q != 3'd5) begin
					step_q <= step_q + 3'd1;
				end else if (!res_full) begin
					step_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ofs_pkg::BK_IDLE) begin
			xs_q   <= xs0;
			xc_q   <= xc0;
			negs_q <= job.hdg[15];
			negc_q <= hc[15];
		end else if (state_q == ofs_pkg::BK_ROT) begin
			unique case (step_q)
				3'd0: begin
					x2s_q <= sq_s[28:14];
					x2c_q <= sq_c[28:14];
				end
				3'd1: begin
					ts_q <= ofs_pkg::SIN_B - 16'(mc_s[26:14]);
					tc_q <= ofs_pkg::SIN_B - 16'(mc_c[26:14]);
				end
				3'd2: begin
					ts_q <= 16'(ofs_pkg::SIN_A - 17'(mt_s[30:14]));
					tc_q <= 16'(ofs_pkg::SIN_A - 17'(mt_c[30:14]));
				end
				3'd3: begin
					sin_q <= negs_q ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
					cos_q <= negc_q ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
				end
				3'd4: begin
					p_q[0] <= $signed(job.n[15:0]) * cos_q;
					p_q[1] <= $signed(job.e[15:0]) * sin_q;
					p_q[2] <= $signed(job.n[15:0]) * sin_q;
					p_q[3] <= $signed(job.e[15:0]) * cos_q;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			ofs_pkg::BK_IDLE: begin
				if (!job_empty) begin
					if (job.vel) begin
						state_d = ofs_pkg::BK_ROT;
					end else if (!res_full) begin
						res_push = 1'b1;
						res.kind = job.kind;
						res.n    = job.n;
						res.e    = job.e;
						res.d    = job.d;
						res.last = !job.two;
						if (job.two) begin
							state_d = ofs_pkg::BK_EMIT2;
						end else begin
							job_pop = 1'b1;
						end
					end
				end
			end
			ofs_pkg::BK_EMIT2: begin
				if (!res_full) begin
					res_push = 1'b1;
					res.kind = ofs_pkg::KIND_OFFBOARD;
					res.last = 1'b1;
					job_pop  = 1'b1;
					state_d  = ofs_pkg::BK_IDLE;
				end
			end
			ofs_pkg::BK_ROT: begin
				if (step_q == 3'd5 && !res_full) begin
					res_push = 1'b1;
					res.kind = ofs_pkg::KIND_VELOCITY;
					res.n    = ofs_pkg::round_q15(sum_n);
					res.e    = ofs_pkg::round_q15(sum_e);
					res.d    = job.d;
					res.r    = job.r;
					res.last = 1'b1;
					job_pop  = 1'b1;
					state_d  = ofs_pkg::BK_IDLE;
				end
			end
			default: state_d = ofs_pkg::BK_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/offboard_flight_sequencer_core.sv @@
// Offboard flight sequencer: event decode and sequence state in front,
// result generation behind a job queue. Depends on ofs_pkg, ofs_fifo,
// ofs_front and ofs_back.
//
// Usage:
//   Input is a queue write port: an event is taken at a clock edge with push
//   high and full low. One event may enter every cycle while the job queue
//   has room; status, position and command events never fill it.
//   Results are a queue read port: while empty is low the oldest result is on
//   the result ports, and pop with empty low takes it.
//   Config: cfg_valid/cfg_ready write register cfg_index; cfg_ready is
//   always high. Indexes past the last register are ignored.
//   Flow: an event's job enters the job queue at the edge that takes it.
//   The back end writes arm, takeoff and hold results into the result queue
//   from the job queue head, a set-offboard result after the takeoff result
//   that carries it, and a velocity result after the sine and rotation steps;
//   it holds while the result queue is full and takes one job at a time.
//   Reset clears the sequence to idle, the front-end state to zero and the
//   registers to their defaults; both queues come up empty.
//   A stalled receiver fills the result queue, then the job queue, and full
//   rises; nothing is dropped.
`default_nettype none
module offboard_flight_sequencer_core #(
	parameter int JOB_DEPTH_LOG2 = 2,
	parameter int RES_DEPTH_LOG2 = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [2:0]         opcode,
	input  wire logic               checks_pass,
	input  wire logic [7:0]         arming_code,
	input  wire logic signed [23:0] north_mm,
	input  wire logic signed [23:0] east_mm,
	input  wire logic signed [23:0] down_mm,
	input  wire logic signed [15:0] heading,
	input  wire logic signed [15:0] fwd_speed,
	input  wire logic signed [15:0] left_speed,
	input  wire logic signed [15:0] up_speed,
	input  wire logic signed [15:0] ccw_rate,
	output logic                    empty,
	input  wire logic               pop,
	output logic [2:0]              kind,
	output logic signed [23:0]      value_north,
	output logic signed [23:0]      value_east,
	output logic signed [23:0]      value_down,
	output logic signed [15:0]      cw_rate,
	output logic                    last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [16:0]        cfg_data
);
	logic          accept;
	logic          job_push, job_full, job_pop, job_empty;
	ofs_pkg::job_t job_in, job_head;
	logic          res_push, res_full;
	ofs_pkg::res_t res_in, res_head;

	assign cfg_ready = 1'b1;
	assign full      = job_full;
	assign accept    = push && !job_full;

	ofs_front u_front (
		.clk, .arst_n, .accept, .opcode, .checks_pass, .arming_code,
		.north_mm, .east_mm, .down_mm, .heading,
		.fwd_speed, .left_speed, .up_speed, .ccw_rate,
		.cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
		.job_push, .job(job_in)
	);

	ofs_fifo #(.WIDTH($bits(ofs_pkg::job_t)), .DEPTH_LOG2(JOB_DEPTH_LOG2)) u_jobq (
		.clk, .arst_n, .push(job_push), .wdata(job_in), .full(job_full),
		.pop(job_pop), .rdata(job_head), .empty(job_empty)
	);

	ofs_back u_back (
		.clk, .arst_n, .job_empty, .job(job_head), .job_pop,
		.res_full, .res_push, .res(res_in)
	);

	ofs_fifo #(.WIDTH($bits(ofs_pkg::res_t)), .DEPTH_LOG2(RES_DEPTH_LOG2)) u_resq (
		.clk, .arst_n, .push(res_push), .wdata(res_in), .full(res_full),
		.pop, .rdata(res_head), .empty
	);

	assign kind        = res_head.kind;
	assign value_north = res_head.n;
	assign value_east  = res_head.e;
	assign value_down  = res_head.d;
	assign cw_rate     = res_head.r;
	assign last        = res_head.last;

	a_job_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	a_res_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(job_pop || res_push) |-> !job_empty)
		else $error("back end worked without a job");

	a_fixed_cw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.kind != ofs_pkg::KIND_VELOCITY) |-> res_in.r == '0)
		else $error("nonzero rate on non-velocity result");
endmodule
`default_nettype wire
